FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// When pre holds, post must hold at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: rtl/wwfv_pkg.sv
// ----------------------------------------------------------------------------
// wwfv_pkg
// Shared types and constants of the windowed wind friction velocity block.
// ----------------------------------------------------------------------------
package wwfv_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 24;
    localparam int SIDE_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_USTAR_GAIN  = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd26214;

    typedef struct packed {
        logic signed [15:0] wind_east;
        logic signed [15:0] wind_north;
        logic        [15:0] surface_ustar;
    } t_in_item;

    typedef struct packed {
        logic [15:0] dust_ustar;
        logic [15:0] wind_ustar;
        logic        wind_dominates;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accum;      // take sample into the window
        logic sq_east;    // square east magnitude
        logic sq_north;   // park east square, square north magnitude
        logic sum_sq;     // form radicand, clear root state
        logic root_step;  // one result bit of the square root
        logic scale;      // root times gain
        logic out_load;   // round, saturate, fill output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;       // next sample closes the window
        logic out_full;   // output register still holds a result
    } t_dp_sts;

endpackage

FILE: rtl/wwfv_stream_if.sv
// ----------------------------------------------------------------------------
// wwfv_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface wwfv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/wwfv_ctrl.sv
// ----------------------------------------------------------------------------
// wwfv_ctrl
// Sequencer: accumulate samples, then square, root, scale and emit once
// per window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wwfv_ctrl #(
    parameter int MAX_WINDOW_SIDE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wwfv_pkg::t_dp_sts i_sts,
    output wwfv_pkg::t_dp_cmd o_cmd
);

    localparam int SUM_W  = 16 + $clog2(MAX_WINDOW_SIDE * MAX_WINDOW_SIDE);
    localparam int ITER_W = $clog2(SUM_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);

    typedef enum logic [2:0] {
        S_ACC,
        S_SQE,
        S_SQN,
        S_SUM,
        S_ROOT,
        S_SCALE,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              acc_fire;

    // a closing sample waits until the previous result has been taken
    assign o_in_ready = (r_state == S_ACC) && (!i_sts.last || !i_sts.out_full);
    assign acc_fire   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        case (r_state)
            S_ACC: begin
                o_cmd.accum = acc_fire;
                if (acc_fire && i_sts.last) begin
                    n_state = S_SQE;
                end
            end
            S_SQE: begin
                o_cmd.sq_east = 1'b1;
                n_state       = S_SQN;
            end
            S_SQN: begin
                o_cmd.sq_north = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_sq = 1'b1;
                n_iter       = '0;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_iter          = r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_ACC;
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    `ASSERT_ALWAYS(a_load_free, i_clk, i_rst_n, !o_cmd.out_load || !i_sts.out_full)
    `ASSERT_NEXT(a_close_starts, i_clk, i_rst_n, acc_fire && i_sts.last, r_state == S_SQE)
    `ASSERT_NEXT(a_root_holds, i_clk, i_rst_n, r_state == S_ROOT && r_iter != ITER_LAST, r_state == S_ROOT)

endmodule

FILE: rtl/wwfv_datapath.sv
// ----------------------------------------------------------------------------
// wwfv_datapath
// Window sums, shared multiplier, bit-serial square root, rounding and the
// output register.
// ----------------------------------------------------------------------------
module wwfv_datapath #(
    parameter int MAX_WINDOW_SIDE = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wwfv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wwfv_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wwfv_pkg::t_dp_cmd                   i_cmd,
    output wwfv_pkg::t_dp_sts                   o_sts,
    input  wwfv_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wwfv_pkg::t_out_item                 o_out_data
);

    localparam int AREA_MAX = MAX_WINDOW_SIDE * MAX_WINDOW_SIDE;
    localparam int SUM_W    = 16 + $clog2(AREA_MAX);
    localparam int CNT_W    = $clog2(AREA_MAX + 1);
    localparam int MB_W     = (SUM_W > wwfv_pkg::GAIN_W) ? SUM_W : wwfv_pkg::GAIN_W;
    localparam int PROD_W   = SUM_W + MB_W;
    localparam int RAD_W    = 2 * SUM_W;
    localparam int REM_W    = SUM_W + 2;

    // configuration
    logic [CNT_W-1:0]              r_area;
    logic [wwfv_pkg::GAIN_W-1:0]   r_gain;
    logic [4:0]                    side_raw, side_c;
    logic [9:0]                    area_full;

    assign side_raw  = {1'b0, i_cfg_wdata[wwfv_pkg::SIDE_W-1:0]};
    assign side_c    = (side_raw == 5'd0) ? 5'd1 :
                       (side_raw > 5'(MAX_WINDOW_SIDE)) ? 5'(MAX_WINDOW_SIDE) : side_raw;
    assign area_full = side_c * side_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= CNT_W'(1);
            r_gain <= wwfv_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wwfv_pkg::REG_WINDOW_SIDE: r_area <= CNT_W'(area_full);
                wwfv_pkg::REG_USTAR_GAIN:  r_gain <= i_cfg_wdata[wwfv_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // window accumulation
    logic signed [SUM_W-1:0] r_east_sum, r_north_sum, n_east_sum, n_north_sum;
    logic        [CNT_W-1:0] r_count;
    logic        [SUM_W-1:0] r_ae, r_an;
    logic        [15:0]      r_surf;

    assign n_east_sum  = r_east_sum + SUM_W'(i_in_data.wind_east);
    assign n_north_sum = r_north_sum + SUM_W'(i_in_data.wind_north);
    assign o_sts.last  = (r_count + CNT_W'(1)) >= r_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_east_sum  <= '0;
            r_north_sum <= '0;
            r_count     <= '0;
        end else if (i_cmd.accum) begin
            if (o_sts.last) begin
                r_east_sum  <= '0;
                r_north_sum <= '0;
                r_count     <= '0;
            end else begin
                r_east_sum  <= n_east_sum;
                r_north_sum <= n_north_sum;
                r_count     <= r_count + CNT_W'(1);
            end
        end
    end

    // magnitudes of the closed window; the most negative sum reads correctly
    // as unsigned
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && o_sts.last) begin
            r_ae   <= n_east_sum[SUM_W-1]  ? SUM_W'(-n_east_sum)  : SUM_W'(n_east_sum);
            r_an   <= n_north_sum[SUM_W-1] ? SUM_W'(-n_north_sum) : SUM_W'(n_north_sum);
            r_surf <= i_in_data.surface_ustar;
        end
    end

    // shared multiplier and square root
    logic [SUM_W-1:0]  mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] mul_p, r_prod;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem, rem_sh, trial;
    logic [SUM_W-1:0]  r_root;
    logic              take_bit;

    assign mul_a = i_cmd.scale ? r_root : (i_cmd.sq_north ? r_an : r_ae);
    assign mul_b = i_cmd.scale ? MB_W'(r_gain) : (i_cmd.sq_north ? MB_W'(r_an) : MB_W'(r_ae));
    assign mul_p = mul_a * mul_b;

    assign rem_sh   = {r_rem[SUM_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial    = {r_root, 2'b01};
    assign take_bit = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_east || i_cmd.sq_north || i_cmd.scale) begin
            r_prod <= mul_p;
        end
        if (i_cmd.sq_north) begin
            r_rad <= r_prod[RAD_W-1:0];
        end else if (i_cmd.sum_sq) begin
            r_rad <= r_rad + r_prod[RAD_W-1:0];
        end else if (i_cmd.root_step) begin
            r_rad <= r_rad << 2;
        end
        if (i_cmd.sum_sq) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rem  <= take_bit ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[SUM_W-2:0], take_bit};
        end
    end

    // round half up, saturate, compare with the surface value
    logic [PROD_W:0] rnd;
    logic [15:0]     wind;
    logic            dom;

    assign rnd  = {1'b0, r_prod} + (PROD_W + 1)'(32768);
    assign wind = (|rnd[PROD_W:32]) ? 16'hFFFF : rnd[31:16];
    assign dom  = wind > r_surf;

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data.dust_ustar     <= dom ? wind : r_surf;
            o_out_data.wind_ustar     <= wind;
            o_out_data.wind_dominates <= dom;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_full = r_out_valid;

endmodule

FILE: rtl/window_wind_friction_velocity.sv
// ----------------------------------------------------------------------------
// window_wind_friction_velocity
// Sums fine-grid wind over a window of side squared samples and turns the
// magnitude of the sums into a friction velocity, compared with the surface
// value carried on the closing sample.
//
//   channel   dir   payload                                     modport
//   i_smp     in    wind_east, wind_north, surface_ustar        sink
//   o_res     out   dust_ustar, wind_ustar, wind_dominates      source
//   cfg       in    i_cfg_we / i_cfg_idx / i_cfg_wdata          write only
//
// Samples inside a window are taken one per cycle.
// The closing sample starts the work on the window (two squares, the sum,
// a one-bit-per-cycle square root of SUM_W steps, scale, output); SUM_W is
// 22 at a maximum window side of 8. No sample is taken during that work.
// A closing sample waits while the previous result is still in o_res.
// Reset (synchronous, active low) clears sums, count, sequencer and output
// valid; window_side resets to 1 and ustar_gain to 26214.
// ----------------------------------------------------------------------------
module window_wind_friction_velocity #(
    parameter int MAX_WINDOW_SIDE = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wwfv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wwfv_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    wwfv_stream_if.sink                     i_smp,
    wwfv_stream_if.source                   o_res
);

    wwfv_pkg::t_dp_cmd   cmd;
    wwfv_pkg::t_dp_sts   sts;
    wwfv_pkg::t_out_item out_data;
    logic                in_ready;
    logic                out_valid;

    wwfv_ctrl #(
        .MAX_WINDOW_SIDE(MAX_WINDOW_SIDE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wwfv_datapath #(
        .MAX_WINDOW_SIDE(MAX_WINDOW_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_smp.data),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_out_data  (out_data)
    );

    assign i_smp.ready = in_ready;
    assign o_res.valid = out_valid;
    assign o_res.data  = out_data;

endmodule
